@@ rtl/core/fpt_pkg.sv @@
// Shared types, constants and entry helpers for the four-level page table mapper.
// No dependencies; every other file but fpt_if imports this package.
package fpt_pkg;

   localparam int NUM_PAGES   = 64;
   localparam int ENTRIES     = 512;
   localparam int IDX_W       = 9;
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int ADDR_W      = PAGE_W + IDX_W;
   localparam int MEM_DEPTH   = NUM_PAGES * ENTRIES;
   localparam int NF_W        = (PAGE_W + 1 > 7) ? PAGE_W + 1 : 7;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_MAPPED = 2'd1,
      ST_NO_PAGES   = 2'd2,
      ST_OUTSIDE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_TABLE_BASE = 2'd0,
      CSR_ROOT_PAGE  = 2'd1,
      CSR_FIRST_FREE = 2'd2
   } csr_index_type;

   // One decoded request as it travels from the front end to the walker.
   typedef struct packed {
      logic        unmap;
      logic [35:0] virt_page;
      logic        nx;
      logic        user;
      logic        write;
      logic [63:0] leaf;
   } work_type;

   // Builds a present entry: no-execute, frame at bits 51..12, user, writable.
   function automatic logic [63:0] make_entry(logic [39:0] frame, logic nx,
                                              logic user, logic write);
      return {nx, 11'd0, frame, 9'd0, user, write, 1'b1};
   endfunction

   // Table index used at a given walk level, top level first.
   function automatic logic [IDX_W-1:0] level_index(logic [35:0] vp, logic [1:0] lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = vp[35:27];
         2'd1:    idx = vp[26:18];
         2'd2:    idx = vp[17:9];
         default: idx = vp[8:0];
      endcase
      return idx;
   endfunction

endpackage

@@ rtl/core/fpt_if.sv @@
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on nothing; the interfaces take no clock or reset.
interface fpt_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [35:0] virt_page;
   logic [39:0] phys_frame;
   logic        writeable;
   logic        user_accessible;
   logic        executable;
   modport source (output valid, command, virt_page, phys_frame, writeable,
                   user_accessible, executable, input ready);
   modport sink   (input valid, command, virt_page, phys_frame, writeable,
                   user_accessible, executable, output ready);
endinterface

interface fpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] leaf_entry;
   logic [1:0]  pages_allocated;
   logic        invalidate_valid;
   logic [35:0] invalidate_page;
   modport source (output valid, status, leaf_entry, pages_allocated,
                   invalidate_valid, invalidate_page, input ready);
   modport sink   (input valid, status, leaf_entry, pages_allocated,
                   invalidate_valid, invalidate_page, output ready);
endinterface

interface fpt_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [39:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/four_level_page_table_mapper.sv @@
// Four-level page table mapper: joins front end, work queue and walker (fpt_pkg, fpt_if).
// A result is registered at the end of its request's walk, which an error ends sooner;
// each level created adds the clearing and linking of its table page to the walk.
// One request is walked at a time, and a new walk starts only once the last result is
// taken; two more requests may wait in the queue behind the front end.
// After reset the store is swept to zero while requests wait in the queue.
module four_level_page_table_mapper
   import fpt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fpt_req_if.sink   req_ch,
   fpt_rsp_if.source rsp_ch,
   fpt_csr_if.sink   csr_ch
);

   // The front end decodes each request transfer into a work item with its leaf
   // entry already built, so the walker only has to walk and write.
   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_not_empty;
   work_type push_item;
   work_type head_item;

   fpt_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // The queue lets the front end keep taking requests while the walker is busy.
   fpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_item)
   );

   // The walker owns the page store, the allocator and the result register.
   fpt_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head      (head_item),
      .pop       (pop),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ rtl/core/fpt_front.sv @@
// Request front end: accepts requests and decodes them into work items.
// Depends on fpt_pkg and fpt_req_if.
module fpt_front
   import fpt_pkg::*;
(
   fpt_req_if.sink  req_ch,
   input  logic     queue_full,
   output logic     push,
   output work_type push_item
);

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   always_comb begin
      push_item.unmap     = req_ch.command;
      push_item.virt_page = req_ch.virt_page;
      push_item.nx        = !req_ch.executable;
      push_item.user      = req_ch.user_accessible;
      push_item.write     = req_ch.writeable;
      push_item.leaf      = make_entry(req_ch.phys_frame, !req_ch.executable,
                                       req_ch.user_accessible, req_ch.writeable);
   end

endmodule

@@ rtl/core/fpt_queue.sv @@
// Short work queue between the front end and the table walker.
// Depends on fpt_pkg.
module fpt_queue
   import fpt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output work_type head
);

   work_type   slot_ff [QUEUE_DEPTH];
   work_type   slot_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       wr_sel;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[0];

   // A push never meets a full queue, so the write slot is the one after the
   // last valid entry once the head has moved up.
   assign wr_sel = count_ff[0] && !pop;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         slot_in[wr_sel] = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

@@ rtl/core/fpt_walker.sv @@
// Table walker: page store, bump allocator, configuration registers and result register.
// Depends on fpt_pkg, fpt_rsp_if and fpt_csr_if.
module fpt_walker
   import fpt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     not_empty,
   input  work_type head,
   output logic     pop,
   fpt_csr_if.sink  csr_ch,
   fpt_rsp_if.source rsp_ch
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_ZERO  = 7'b0010000,
      S_LINK  = 7'b0100000,
      S_LEAF  = 7'b1000000
   } state_type;

   logic [63:0] mem [MEM_DEPTH];
   logic [63:0] rdata_ff;

   state_type   state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        lvl_ff, lvl_in;
   logic [PAGE_W-1:0] tbl_ff, tbl_in;
   logic [ADDR_W-1:0] link_addr_ff, link_addr_in;
   logic [63:0]       link_entry_ff, link_entry_in;
   work_type          cur_ff, cur_in;
   logic [1:0]        allocs_ff, allocs_in;
   logic [NF_W-1:0]   next_free_ff, next_free_in;
   logic [39:0]       base_ff, base_in;
   logic [5:0]        root_ff, root_in;
   logic              ov_ff, ov_in;
   logic [1:0]        ost_ff, ost_in;
   logic [63:0]       oleaf_ff, oleaf_in;
   logic [1:0]        oalloc_ff, oalloc_in;
   logic              oinv_ff, oinv_in;
   logic [35:0]       opage_ff, opage_in;

   logic              we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [63:0]       wdata;
   logic              fin;
   status_type        fin_st;
   logic [39:0]       rel_page;
   logic              csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   assign rsp_ch.valid            = ov_ff;
   assign rsp_ch.status           = ost_ff;
   assign rsp_ch.leaf_entry       = oleaf_ff;
   assign rsp_ch.pages_allocated  = oalloc_ff;
   assign rsp_ch.invalidate_valid = oinv_ff;
   assign rsp_ch.invalidate_page  = opage_ff;

   assign rel_page = rdata_ff[51:12] - base_ff;
   assign raddr    = {tbl_ff, level_index(cur_ff.virt_page, lvl_ff)};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      lvl_in        = lvl_ff;
      tbl_in        = tbl_ff;
      link_addr_in  = link_addr_ff;
      link_entry_in = link_entry_ff;
      cur_in        = cur_ff;
      allocs_in     = allocs_ff;
      next_free_in  = next_free_ff;
      base_in       = base_ff;
      root_in       = root_ff;
      we            = 1'b0;
      waddr         = raddr;
      wdata         = 64'd0;
      fin           = 1'b0;
      fin_st        = ST_OK;
      pop           = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (not_empty && !ov_ff) begin
               pop       = 1'b1;
               cur_in    = head;
               allocs_in = 2'd0;
               lvl_in    = 2'd0;
               tbl_in    = PAGE_W'(root_ff);
               if (int'(root_ff) >= NUM_PAGES) begin
                  fin    = 1'b1;
                  fin_st = ST_OUTSIDE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (rdata_ff[0]) begin
               if (rel_page >= 40'(NUM_PAGES)) begin
                  fin      = 1'b1;
                  fin_st   = ST_OUTSIDE;
                  state_in = S_IDLE;
               end else begin
                  tbl_in   = rel_page[PAGE_W-1:0];
                  lvl_in   = lvl_ff + 2'd1;
                  state_in = (lvl_ff == 2'd2) ? S_LEAF : S_READ;
               end
            end else if (cur_ff.unmap) begin
               fin      = 1'b1;
               fin_st   = ST_NOT_MAPPED;
               state_in = S_IDLE;
            end else if (next_free_ff >= NF_W'(NUM_PAGES)) begin
               fin      = 1'b1;
               fin_st   = ST_NO_PAGES;
               state_in = S_IDLE;
            end else begin
               link_addr_in  = raddr;
               link_entry_in = make_entry(base_ff + 40'(next_free_ff), cur_ff.nx,
                                          cur_ff.user, cur_ff.write);
               tbl_in        = next_free_ff[PAGE_W-1:0];
               next_free_in  = next_free_ff + NF_W'(1);
               allocs_in     = allocs_ff + 2'd1;
               cnt_in        = '0;
               state_in      = S_ZERO;
            end
         end
         S_ZERO: begin
            we     = 1'b1;
            waddr  = {tbl_ff, cnt_ff};
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            we       = 1'b1;
            waddr    = link_addr_ff;
            wdata    = link_entry_ff;
            lvl_in   = lvl_ff + 2'd1;
            state_in = (lvl_ff == 2'd2) ? S_LEAF : S_READ;
         end
         S_LEAF: begin
            we       = 1'b1;
            waddr    = {tbl_ff, cur_ff.virt_page[8:0]};
            wdata    = cur_ff.unmap ? 64'd0 : cur_ff.leaf;
            fin      = 1'b1;
            fin_st   = ST_OK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_fire) begin
         case (csr_ch.index)
            CSR_TABLE_BASE: base_in      = csr_ch.data;
            CSR_ROOT_PAGE:  root_in      = csr_ch.data[5:0];
            CSR_FIRST_FREE: next_free_in = NF_W'(csr_ch.data[6:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      ov_in     = ov_ff;
      ost_in    = ost_ff;
      oleaf_in  = oleaf_ff;
      oalloc_in = oalloc_ff;
      oinv_in   = oinv_ff;
      opage_in  = opage_ff;
      if (ov_ff && rsp_ch.ready) begin
         ov_in = 1'b0;
      end
      if (fin) begin
         ov_in     = 1'b1;
         ost_in    = fin_st;
         oleaf_in  = (fin_st == ST_OK && !cur_in.unmap) ? cur_in.leaf : 64'd0;
         oalloc_in = allocs_in;
         oinv_in   = (fin_st == ST_OK);
         opage_in  = (fin_st == ST_OK) ? cur_in.virt_page : 36'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= NF_W'(1);
         base_ff      <= 40'd0;
         root_ff      <= 6'd0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         base_ff      <= base_in;
         root_ff      <= root_in;
         ov_ff        <= ov_in;
      end
      cnt_ff        <= cnt_in;
      lvl_ff        <= lvl_in;
      tbl_ff        <= tbl_in;
      link_addr_ff  <= link_addr_in;
      link_entry_ff <= link_entry_in;
      cur_ff        <= cur_in;
      allocs_ff     <= allocs_in;
      ost_ff        <= ost_in;
      oleaf_ff      <= oleaf_in;
      oalloc_ff     <= oalloc_in;
      oinv_ff       <= oinv_in;
      opage_ff      <= opage_in;
   end

`ifndef NO_ASSERTIONS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_READ || state_ff == S_EVAL) |-> !we)
      else $error("page store written outside a write state");
   a_pop_only_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!ov_ff && state_ff == S_IDLE))
      else $error("work taken while a result is pending");
   a_ok_invalidates: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && ost_ff == ST_OK) |-> oinv_ff)
      else $error("successful result without invalidate");
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_EVAL && state_ff == S_ZERO && !$past(csr_fire))
      |-> next_free_ff == $past(next_free_ff) + NF_W'(1))
      else $error("allocator did not advance on a new level");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the four-level page table mapper.
// Depends on fpt_pkg and the channel interfaces in fpt_if; drives requests and
// register writes, and checks every response against a built-in table walker.
module testbench;
   import fpt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic CMD_MAP   = 1'b0;
   localparam logic CMD_UNMAP = 1'b1;
   localparam int   WATCHDOG_LIMIT = 200000;

   typedef struct {
      logic        command;
      logic [35:0] virt_page;
      logic [39:0] phys_frame;
      logic        writeable;
      logic        user_accessible;
      logic        executable;
   } request_type;

   typedef struct {
      status_type  status;
      logic [63:0] leaf_entry;
      logic [1:0]  pages_allocated;
      logic        invalidate_valid;
      logic [35:0] invalidate_page;
   } response_type;

   // The scoreboard carries its own copy of the table store and allocator,
   // walks every accepted request, and queues the response it should produce.
   class walk_scoreboard;
      logic [63:0]  store [NUM_PAGES*ENTRIES];
      logic [39:0]  base_frame;
      logic [5:0]   root;
      logic [6:0]   next_free;
      response_type pending [$];
      int           errors;

      function new();
         foreach (store[i]) store[i] = '0;
         base_frame = '0;
         root       = '0;
         next_free  = 7'd1;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [39:0] value);
         case (idx)
            CSR_TABLE_BASE: base_frame = value;
            CSR_ROOT_PAGE:  root = value[5:0];
            CSR_FIRST_FREE: next_free = value[6:0];
            default: ;
         endcase
      endfunction

      function void note(request_type r);
         response_type exp;
         logic [63:0]  flags, e;
         logic [39:0]  pg, frame;
         logic [8:0]   idx [4];
         int           tbl, slot, lvl, allocs;
         status_type   st;
         flags  = 64'(r.writeable) << 1 | 64'(r.user_accessible) << 2
                | (r.executable ? 64'd0 : 64'd1 << 63);
         idx[0] = r.virt_page[35:27];
         idx[1] = r.virt_page[26:18];
         idx[2] = r.virt_page[17:9];
         idx[3] = r.virt_page[8:0];
         st     = ST_OK;
         allocs = 0;
         tbl    = root;
         exp.leaf_entry = '0;
         for (lvl = 0; lvl < 3 && st == ST_OK; lvl++) begin
            slot = tbl * ENTRIES + idx[lvl];
            e    = store[slot];
            if (e[0]) begin
               pg = e[51:12] - base_frame;
               if (pg >= NUM_PAGES) st = ST_OUTSIDE;
               else tbl = pg;
            end else if (r.command == CMD_UNMAP) begin
               st = ST_NOT_MAPPED;
            end else if (next_free >= NUM_PAGES) begin
               st = ST_NO_PAGES;
            end else begin
               // A fresh table page is cleared and linked into its parent.
               frame = base_frame + next_free;
               for (int i = 0; i < ENTRIES; i++) store[next_free * ENTRIES + i] = '0;
               store[slot] = (64'(frame) << 12) | flags | 64'd1;
               tbl = next_free;
               next_free++;
               allocs++;
            end
         end
         if (st == ST_OK) begin
            slot = tbl * ENTRIES + idx[3];
            if (r.command == CMD_MAP)
               exp.leaf_entry = (64'(r.phys_frame) << 12) | flags | 64'd1;
            store[slot] = exp.leaf_entry;
         end
         exp.status           = st;
         exp.pages_allocated  = allocs[1:0];
         exp.invalidate_valid = (st == ST_OK);
         exp.invalidate_page  = (st == ST_OK) ? r.virt_page : '0;
         pending.push_back(exp);
      endfunction

      function void check(response_type act);
         response_type exp;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected, status %0d", $time, act.status);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (act.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, act.status);
            errors++;
         end
         if (act.leaf_entry !== exp.leaf_entry) begin
            $display("%0t: leaf_entry expected %h actual %h", $time,
                     exp.leaf_entry, act.leaf_entry);
            errors++;
         end
         if (act.pages_allocated !== exp.pages_allocated) begin
            $display("%0t: pages_allocated expected %0d actual %0d", $time,
                     exp.pages_allocated, act.pages_allocated);
            errors++;
         end
         if (act.invalidate_valid !== exp.invalidate_valid) begin
            $display("%0t: invalidate_valid expected %b actual %b", $time,
                     exp.invalidate_valid, act.invalidate_valid);
            errors++;
         end
         if (act.invalidate_page !== exp.invalidate_page) begin
            $display("%0t: invalidate_page expected %h actual %h", $time,
                     exp.invalidate_page, act.invalidate_page);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   quiet_cycles = 0;
   walk_scoreboard sb = new();

   fpt_req_if req_ch();
   fpt_rsp_if rsp_ch();
   fpt_csr_if csr_ch();

   four_level_page_table_mapper dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Every input starts at a known value; reset is held once at the start and then released.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = CMD_MAP;
      req_ch.virt_page = '0;
      req_ch.phys_frame = '0;
      req_ch.writeable = 1'b0;
      req_ch.user_accessible = 1'b0;
      req_ch.executable = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_TABLE_BASE;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Response side: every transfer is checked, and ready idles about a third
   // of the time unless the no-idle phase is active.
   always @(posedge clock) begin
      response_type act;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act.status           = status_type'(rsp_ch.status);
         act.leaf_entry       = rsp_ch.leaf_entry;
         act.pages_allocated  = rsp_ch.pages_allocated;
         act.invalidate_valid = rsp_ch.invalidate_valid;
         act.invalidate_page  = rsp_ch.invalidate_page;
         sb.check(act);
      end
      rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);
   end

   // The watchdog counts cycles without any transfer on any channel. The
   // post-reset sweep of the store and long level clears fit well inside it.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("[four_level_page_table_mapper] ERROR");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [39:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Sends one request. Valid may first drop for an idle pause outside the no-idle
   // phase; otherwise it stays high straight into the next transfer.
   task automatic send(request_type r);
      if (!no_idle && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.command         <= r.command;
      req_ch.virt_page       <= r.virt_page;
      req_ch.phys_frame      <= r.phys_frame;
      req_ch.writeable       <= r.writeable;
      req_ch.user_accessible <= r.user_accessible;
      req_ch.executable      <= r.executable;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(r);
   endtask

   // The sender holds off until every outstanding response has arrived, so the
   // block is idle before the registers change.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic request_type make_req(logic cmd, logic [35:0] vp, logic [39:0] pf,
                                            logic w, logic u, logic x);
      request_type r;
      r.command = cmd; r.virt_page = vp; r.phys_frame = pf;
      r.writeable = w; r.user_accessible = u; r.executable = x;
      return r;
   endfunction

   // Each index favors zero, the top entry or a small cluster, so walks keep
   // landing on tables that already exist; the rest are fully random.
   function automatic logic [8:0] pick_index();
      case ($urandom_range(0, 3))
         0:       return 9'd0;
         1:       return 9'h1ff;
         2:       return 9'($urandom_range(0, 3));
         default: return 9'($urandom);
      endcase
   endfunction

   function automatic request_type random_req();
      logic [35:0] vp;
      logic [39:0] pf;
      vp = {pick_index(), pick_index(), pick_index(), pick_index()};
      pf = {8'($urandom), 32'($urandom)};
      return make_req(($urandom_range(0, 99) < 30) ? CMD_UNMAP : CMD_MAP, vp, pf,
                      1'($urandom), 1'($urandom), 1'($urandom));
   endfunction

   initial begin
      logic [39:0] bases [5] = '{40'hff_ffff_ffff, 40'hff_ffff_ffff, 40'd5, 40'd0, 40'd12345};
      logic [5:0]  roots [5] = '{6'd63, 6'd63, 6'd10, 6'd0, 6'd32};
      logic [6:0]  frees [5] = '{7'd0, 7'd64, 7'd11, 7'd40, 7'd60};

      @(negedge reset);
      @(posedge clock);
      write_csr(CSR_TABLE_BASE, 40'd0);
      write_csr(CSR_ROOT_PAGE, 40'd0);
      write_csr(CSR_FIRST_FREE, 40'd1);

      // Directed part: first map builds all three levels, neighbors share
      // them, unmaps hit an absent leaf, a missing level and a mapped page.
      send(make_req(CMD_MAP, 36'd0, 40'd0, 1'b1, 1'b1, 1'b1));
      send(make_req(CMD_MAP, 36'hf_ffff_ffff, 40'hff_ffff_ffff, 1'b0, 1'b0, 1'b0));
      send(make_req(CMD_MAP, 36'd1, 40'h55_aaaa_5555, 1'b1, 1'b0, 1'b0));
      send(make_req(CMD_MAP, 36'd2, 40'haa_5555_aaaa, 1'b0, 1'b1, 1'b1));
      send(make_req(CMD_UNMAP, 36'd3, 40'd0, 1'b0, 1'b0, 1'b0));
      send(make_req(CMD_UNMAP, 36'h8_0000_0000, 40'd0, 1'b1, 1'b1, 1'b1));
      send(make_req(CMD_UNMAP, 36'd0, 40'd0, 1'b0, 1'b0, 1'b1));
      send(make_req(CMD_MAP, 36'd0, 40'd7, 1'b1, 1'b1, 1'b0));
      send(make_req(CMD_UNMAP, 36'hf_ffff_ffff, 40'd0, 1'b0, 1'b0, 1'b0));
      send(make_req(CMD_UNMAP, 36'hf_ffff_ffff, 40'd0, 1'b0, 1'b0, 1'b0));
      send(make_req(CMD_UNMAP, 36'h0_0004_0000, 40'd0, 1'b0, 1'b0, 1'b0));
      for (int i = 0; i < 190; i++) send(random_req());

      // Each later phase changes every register after the queue drains. The
      // rebased frames turn old entries into pointers outside the store, an
      // allocator at 64 runs dry at once, and one phase runs without idling.
      for (int p = 0; p < 5; p++) begin
         drain();
         write_csr(CSR_TABLE_BASE, bases[p]);
         write_csr(CSR_ROOT_PAGE, 40'(roots[p]));
         write_csr(CSR_FIRST_FREE, 40'(frees[p]));
         no_idle = (p == 3);
         for (int i = 0; i < 200; i++) send(random_req());
      end
      no_idle = 1'b0;
      req_ch.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[four_level_page_table_mapper] OK");
      end else begin
         $display("[four_level_page_table_mapper] ERROR");
      end
      $finish;
   end

endmodule
